>>> rtl/hnf_pkg.sv
// ----------------------------------------------------------------------------
// hnf_pkg
// Shared constants, the item descriptor passed from front to back, and the
// character helper functions of the hex number formatter.
// ----------------------------------------------------------------------------
package hnf_pkg;

   localparam int MAX_FIELD   = 60;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [5:0] MAX_FIELD_W = 6'(MAX_FIELD);

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_A_LO  = 8'h61;
   localparam logic [7:0] CHAR_A_UP  = 8'h41;

   typedef struct packed {
      logic        nil;
      logic        upper;
      logic [63:0] value;
      logic [5:0]  b_lead;
      logic [5:0]  b_pfx;
      logic [5:0]  b_zero;
      logic [5:0]  b_dig;
      logic [5:0]  last_pos;
   } hnf_desc_type;

   function automatic logic [4:0] digit_count(input logic [63:0] v);
      logic [4:0] n;
      n = 5'd1;
      for (int i = 1; i < 16; i++) begin
         if (v[4*i +: 4] != 4'h0) begin
            n = 5'(i + 1);
         end
      end
      return n;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'h0, nib};
      end else begin
         c = (upper ? CHAR_A_UP : CHAR_A_LO) + {4'h0, nib} - 8'd10;
      end
      return c;
   endfunction

   function automatic logic [7:0] nil_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h28;
         3'd1:    c = 8'h6E;
         3'd2:    c = 8'h69;
         3'd3:    c = 8'h6C;
         3'd4:    c = 8'h29;
         default: c = CHAR_SPACE;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/hnf_front.sv
// ----------------------------------------------------------------------------
// hnf_front
// Classifies one format request: saturates width and precision, counts
// digits and works out the character position where each segment ends.
// ----------------------------------------------------------------------------
module hnf_front (
   input  logic                 req_cmd,
   input  logic [63:0]          req_value,
   input  logic [5:0]           req_min_width,
   input  logic [5:0]           req_precision,
   input  logic                 req_has_precision,
   input  logic                 req_left_align,
   input  logic                 req_zero_pad,
   input  logic                 req_alt_prefix,
   input  logic                 req_upper_case,
   output hnf_pkg::hnf_desc_type desc,
   output logic                 desc_empty
);
   import hnf_pkg::*;

   logic [5:0] width_sat;
   logic [5:0] prec_eff;
   logic [4:0] len;
   logic       prefix;
   logic [6:0] digits_total;
   logic [6:0] body;
   logic [6:0] pad;
   logic [6:0] zeros;
   logic [6:0] lead;
   logic [6:0] trail;
   logic [6:0] s_pfx;
   logic [6:0] s_zero;
   logic [6:0] s_dig;
   logic [6:0] total;

   always_comb begin
      width_sat = (req_min_width > MAX_FIELD_W) ? MAX_FIELD_W : req_min_width;
      prec_eff  = req_has_precision ?
                  ((req_precision > MAX_FIELD_W) ? MAX_FIELD_W : req_precision) : 6'd0;

      if (req_cmd) begin
         len          = digit_count(req_value);
         prefix       = 1'b1;
         digits_total = {2'b00, len};
      end else begin
         len = digit_count({32'h0, req_value[31:0]});
         if (req_value[31:0] == 32'h0 && req_has_precision && prec_eff == 6'd0) begin
            len = 5'd0;
         end
         prefix       = req_alt_prefix && (req_value[31:0] != 32'h0);
         digits_total = ({1'b0, prec_eff} > {2'b00, len}) ? {1'b0, prec_eff} : {2'b00, len};
      end

      body  = digits_total + (prefix ? 7'd2 : 7'd0);
      pad   = ({1'b0, width_sat} > body) ? ({1'b0, width_sat} - body) : 7'd0;
      zeros = digits_total - {2'b00, len};
      if (!req_cmd && req_zero_pad && !req_has_precision && !req_left_align) begin
         zeros = zeros + pad;
         pad   = 7'd0;
      end

      lead   = req_left_align ? 7'd0 : pad;
      trail  = req_left_align ? pad : 7'd0;
      s_pfx  = lead + (prefix ? 7'd2 : 7'd0);
      s_zero = s_pfx + zeros;
      s_dig  = s_zero + {2'b00, len};
      total  = s_dig + trail;

      desc.nil    = req_cmd && (req_value == 64'h0);
      desc.upper  = !req_cmd && req_upper_case;
      desc.value  = req_cmd ? req_value : {32'h0, req_value[31:0]};
      desc.b_lead = lead[5:0];
      desc.b_pfx  = s_pfx[5:0];
      desc.b_zero = s_zero[5:0];
      desc.b_dig  = s_dig[5:0];
      if (desc.nil) begin
         desc.last_pos = 6'd4;
         desc_empty    = 1'b0;
      end else begin
         desc.last_pos = 6'(total - 7'd1);
         desc_empty    = (total == 7'd0);
      end
   end

endmodule

>>> rtl/hnf_queue.sv
// ----------------------------------------------------------------------------
// hnf_queue
// Short descriptor queue between front and back, held in flip-flops.
// ----------------------------------------------------------------------------
module hnf_queue #(
   parameter int DEPTH = hnf_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hnf_pkg::hnf_desc_type push_data,
   output logic                  full,
   input  logic                  pop,
   output hnf_pkg::hnf_desc_type pop_data,
   output logic                  valid
);
   import hnf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   hnf_desc_type  slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full     = (count_ff == DEPTH_C);
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_in    = do_push ? ((wr_ff == LAST_IDX) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop ? ((rd_ff == LAST_IDX) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/hnf_back.sv
// ----------------------------------------------------------------------------
// hnf_back
// Walks a descriptor a character per unstalled cycle into the result register.
// ----------------------------------------------------------------------------
module hnf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  hnf_pkg::hnf_desc_type q_data,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last
);
   import hnf_pkg::*;

   hnf_desc_type desc_ff, desc_in;
   logic         busy_ff, busy_in;
   logic [5:0]   pos_ff, pos_in;
   logic         out_valid_ff, out_valid_in;
   logic [7:0]   out_char_ff, out_char_in;
   logic         out_last_ff, out_last_in;
   logic         emit;
   logic         is_last;
   logic         load;
   logic [5:0]   dig_idx;
   logic [3:0]   nib;
   logic [7:0]   ch;

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = out_last_ff;

   assign emit    = busy_ff && (!out_valid_ff || rsp_pop);
   assign is_last = (pos_ff == desc_ff.last_pos);
   assign load    = q_valid && (!busy_ff || (emit && is_last));
   assign q_pop   = load;

   always_comb begin
      dig_idx = desc_ff.b_dig - 6'd1 - pos_ff;
      nib     = desc_ff.value[{dig_idx[3:0], 2'b00} +: 4];
      if (desc_ff.nil) begin
         ch = nil_char(pos_ff[2:0]);
      end else if (pos_ff < desc_ff.b_lead) begin
         ch = CHAR_SPACE;
      end else if (pos_ff < desc_ff.b_pfx) begin
         ch = (pos_ff == desc_ff.b_lead) ? CHAR_ZERO :
              (desc_ff.upper ? CHAR_X_UP : CHAR_X_LO);
      end else if (pos_ff < desc_ff.b_zero) begin
         ch = CHAR_ZERO;
      end else if (pos_ff < desc_ff.b_dig) begin
         ch = hex_char(nib, desc_ff.upper);
      end else begin
         ch = CHAR_SPACE;
      end

      desc_in      = desc_ff;
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = ch;
         out_last_in  = is_last;
         pos_in       = pos_ff + 6'd1;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      if (load) begin
         desc_in = q_data;
         busy_in = 1'b1;
         pos_in  = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      desc_ff     <= desc_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

>>> rtl/hex_number_formatter.sv
// ----------------------------------------------------------------------------
// hex_number_formatter
// Formats a number as printf-style hex or pointer text, one character per
// result item.
//
// Request side is a queue: drive the fields and push while full is low.
// cmd 0 prints the low 32 bits as %x/%X with width, precision, alignment,
// zero fill and prefix; cmd 1 prints all 64 bits as a pointer.
// Response side is a queue: while empty is low, out_char holds the next
// character and last marks the final character of its item; pop takes it.
// An item that formats to no characters produces no response.
// The first character passes through the descriptor queue, the back end's
// descriptor register and the result register. One character per cycle
// leaves while the receiver pops; an item has 1 to 62 characters, and a
// two-entry descriptor queue takes new requests while the back end works.
// A stalled receiver holds the current character and stops the back end;
// full rises once the queue fills. Reset empties queue and result register.
// ----------------------------------------------------------------------------
module hex_number_formatter #(
   parameter int QUEUE_DEPTH = hnf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [63:0] req_value,
   input  logic [5:0]  req_min_width,
   input  logic [5:0]  req_precision,
   input  logic        req_has_precision,
   input  logic        req_left_align,
   input  logic        req_zero_pad,
   input  logic        req_alt_prefix,
   input  logic        req_upper_case,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);
   import hnf_pkg::*;

   hnf_desc_type front_desc;
   logic         front_empty;
   hnf_desc_type q_data;
   logic         q_valid;
   logic         q_pop;
   logic         q_push;

   assign q_push = req_push && !req_full && !front_empty;

   hnf_front u_front (
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .req_min_width     (req_min_width),
      .req_precision     (req_precision),
      .req_has_precision (req_has_precision),
      .req_left_align    (req_left_align),
      .req_zero_pad      (req_zero_pad),
      .req_alt_prefix    (req_alt_prefix),
      .req_upper_case    (req_upper_case),
      .desc              (front_desc),
      .desc_empty        (front_empty)
   );

   hnf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_desc),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .valid     (q_valid)
   );

   hnf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

>>> tb/hex_number_formatter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_number_formatter_test
// Pushes hex and pointer format requests into the formatter, first from a
// table of directed cases and then at random, with random gaps on the
// request side and random stalls on the character side. Every character
// popped is compared with the text predicted for its item.
// ----------------------------------------------------------------------------
module hex_number_formatter_test;

   import hnf_pkg::*;

   localparam int IDLE_LIMIT     = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 250;
   localparam int MAX_GAP        = 17;
   localparam int MISMATCH_SHOWN = 10;

   typedef enum bit {
      CMD_HEX     = 1'b0,
      CMD_POINTER = 1'b1
   } format_cmd_type;

   typedef struct packed {
      format_cmd_type cmd;
      logic [63:0]    value;
      logic [5:0]     min_width;
      logic [5:0]     precision;
      logic           has_precision;
      logic           left_align;
      logic           zero_pad;
      logic           alt_prefix;
      logic           upper_case;
   } format_item_type;

   typedef struct {
      format_item_type item;
      bit              typed;
      string           text;
   } directed_row_type;

   typedef struct {
      byte unsigned ch;
      bit           last;
      int           item_no;
   } expected_char_type;

   typedef byte unsigned char_list_type[$];

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_push          = 1'b0;
   logic        req_full;
   logic        req_cmd           = 1'b0;
   logic [63:0] req_value         = '0;
   logic [5:0]  req_min_width     = '0;
   logic [5:0]  req_precision     = '0;
   logic        req_has_precision = 1'b0;
   logic        req_left_align    = 1'b0;
   logic        req_zero_pad      = 1'b0;
   logic        req_alt_prefix    = 1'b0;
   logic        req_upper_case    = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop           = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last;

   expected_char_type expected_chars[$];
   int                mismatch_count = 0;
   int                items_sent     = 0;
   int                idle_cycles    = 0;
   bit                send_gaps_on   = 1'b1;
   bit                pop_stalls_on  = 1'b1;

   // cmd, value, min_width, precision, has_precision, left_align, zero_pad,
   // alt_prefix, upper_case
   directed_row_type directed_rows [23] = '{
      '{'{CMD_HEX,     64'h0,                   6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b1, "0"},
      '{'{CMD_HEX,     64'h0,                   6'd0,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b1, ""},
      '{'{CMD_HEX,     64'h0,                   6'd5,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b1, "     "},
      '{'{CMD_POINTER, 64'h0,                   6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b1, "(nil)"},
      '{'{CMD_POINTER, 64'h0,                   6'd20, 6'd7,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        1'b1, "(nil)"},
      '{'{CMD_POINTER, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b1, "0xffffffffffffffff"},
      '{'{CMD_HEX,     64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1},
        1'b1, "0XFFFFFFFF"},
      '{'{CMD_HEX,     64'h0000_0000_DEAD_BEEF, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0},
        1'b1, "0xdeadbeef"},
      '{'{CMD_HEX,     64'h0,                   6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1},
        1'b1, "0"},
      '{'{CMD_HEX,     64'h1,                   6'd63, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b0, ""},
      '{'{CMD_HEX,     64'h5,                   6'd0,  6'd63, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b0, ""},
      '{'{CMD_HEX,     64'h7F,                  6'd0,  6'd40, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b0, ""},
      '{'{CMD_HEX,     64'hAB,                  6'd12, 6'd0,  1'b0, 1'b0, 1'b1, 1'b1, 1'b0},
        1'b1, "0x00000000ab"},
      '{'{CMD_HEX,     64'h1F,                  6'd8,  6'd4,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
        1'b1, "    001f"},
      '{'{CMD_HEX,     64'hA,                   6'd6,  6'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
        1'b1, "a     "},
      '{'{CMD_HEX,     64'h3C,                  6'd10, 6'd0,  1'b0, 1'b1, 1'b0, 1'b1, 1'b1},
        1'b1, "0X3C      "},
      '{'{CMD_POINTER, 64'h1,                   6'd63, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b0, ""},
      '{'{CMD_POINTER, 64'h1_2345_6789,         6'd30, 6'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        1'b0, ""},
      '{'{CMD_POINTER, 64'hAB_CDEF,             6'd10, 6'd5,  1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
        1'b1, "  0xabcdef"},
      '{'{CMD_HEX,     64'hFFFF_FFFF,           6'd60, 6'd60, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0},
        1'b0, ""},
      '{'{CMD_POINTER, 64'h8000_0000_0000_0000, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        1'b1, "0x8000000000000000"},
      '{'{CMD_HEX,     64'hFFFF_FFFF_0000_0000, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0},
        1'b1, "0"},
      '{'{CMD_HEX,     64'h0,                   6'd63, 6'd0,  1'b0, 1'b0, 1'b1, 1'b1, 1'b1},
        1'b0, ""}
   };

   hex_number_formatter dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .req_min_width     (req_min_width),
      .req_precision     (req_precision),
      .req_has_precision (req_has_precision),
      .req_left_align    (req_left_align),
      .req_zero_pad      (req_zero_pad),
      .req_alt_prefix    (req_alt_prefix),
      .req_upper_case    (req_upper_case),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_char      (rsp_out_char),
      .rsp_last          (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic char_list_type format_text(input format_item_type it);
      char_list_type text;
      logic [63:0]   v;
      int            width, prec, len, digits, body, pad, zeros;
      bit            prefix, upper;
      string         glyphs;
      width = (it.min_width > MAX_FIELD) ? MAX_FIELD : int'(it.min_width);
      prec  = (it.precision > MAX_FIELD) ? MAX_FIELD : int'(it.precision);
      if (!it.has_precision || it.cmd == CMD_POINTER) begin
         prec = 0;
      end
      if (it.cmd == CMD_POINTER) begin
         if (it.value == 64'h0) begin
            glyphs = "(nil)";
            for (int i = 0; i < glyphs.len(); i++) begin
               text.push_back(glyphs[i]);
            end
            return text;
         end
         v      = it.value;
         upper  = 1'b0;
         prefix = 1'b1;
      end else begin
         v      = {32'h0, it.value[31:0]};
         upper  = it.upper_case;
         prefix = it.alt_prefix && v != 64'h0;
      end
      len = 16;
      while (len > 1 && v[4*len-1 -: 4] == 4'h0) begin
         len--;
      end
      if (it.cmd == CMD_HEX && v == 64'h0 && it.has_precision && prec == 0) begin
         len = 0;
      end
      digits = (prec > len) ? prec : len;
      body   = digits + (prefix ? 2 : 0);
      pad    = (width > body) ? width - body : 0;
      zeros  = digits - len;
      if (it.cmd == CMD_HEX && it.zero_pad && !it.has_precision && !it.left_align) begin
         zeros += pad;
         pad = 0;
      end
      glyphs = upper ? "0123456789ABCDEF" : "0123456789abcdef";
      if (!it.left_align) begin
         repeat (pad) text.push_back(" ");
      end
      if (prefix) begin
         text.push_back("0");
         text.push_back(upper ? "X" : "x");
      end
      repeat (zeros) text.push_back("0");
      for (int i = len - 1; i >= 0; i--) begin
         text.push_back(glyphs[int'(v[4*i +: 4])]);
      end
      if (it.left_align) begin
         repeat (pad) text.push_back(" ");
      end
      return text;
   endfunction

   task automatic send_item(input format_item_type it, input bit typed,
                            input string typed_text);
      int                gap;
      char_list_type     text;
      expected_char_type want;
      gap = send_gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push          <= 1'b1;
      req_cmd           <= it.cmd;
      req_value         <= it.value;
      req_min_width     <= it.min_width;
      req_precision     <= it.precision;
      req_has_precision <= it.has_precision;
      req_left_align    <= it.left_align;
      req_zero_pad      <= it.zero_pad;
      req_alt_prefix    <= it.alt_prefix;
      req_upper_case    <= it.upper_case;
      do @(posedge clock); while (req_full);
      if (typed) begin
         for (int i = 0; i < typed_text.len(); i++) begin
            text.push_back(typed_text[i]);
         end
      end else begin
         text = format_text(it);
      end
      for (int i = 0; i < text.size(); i++) begin
         want.ch      = text[i];
         want.last    = (i == text.size() - 1);
         want.item_no = items_sent;
         expected_chars.push_back(want);
      end
      items_sent++;
   endtask

   initial begin
      int                stall;
      expected_char_type want;
      wait (!reset);
      forever begin
         stall = pop_stalls_on ? $urandom_range(MAX_GAP, 0) : 0;
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN) begin
               $display("unexpected char: out_char %h last %b", rsp_out_char, rsp_last);
            end
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_char !== want.ch || rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN) begin
                  $display("item %0d: expected out_char %h last %b, got out_char %h last %b",
                           want.item_no, want.ch, want.last, rsp_out_char, rsp_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
         $display("** hex_number_formatter: FAILED **");
         $finish;
      end
   end

   initial begin
      format_item_type item;
      int              sel;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[r]) begin
         send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].text);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0) begin
            send_gaps_on  = ($urandom_range(3, 0) != 0);
            pop_stalls_on = ($urandom_range(3, 0) != 0);
         end
         item.cmd   = format_cmd_type'($urandom_range(1, 0));
         item.value = {$urandom, $urandom};
         sel = $urandom_range(7, 0);
         if (sel == 0) begin
            item.value = 64'h0;
         end else if (sel < 4) begin
            item.value = item.value >> (4 * $urandom_range(15, 0));
         end
         item.min_width     = ($urandom_range(3, 0) == 0) ? 6'($urandom_range(63, 0))
                                                          : 6'($urandom_range(20, 0));
         item.precision     = ($urandom_range(3, 0) == 0) ? 6'($urandom_range(63, 0))
                                                          : 6'($urandom_range(12, 0));
         item.has_precision = 1'($urandom_range(1, 0));
         item.left_align    = 1'($urandom_range(1, 0));
         item.zero_pad      = 1'($urandom_range(1, 0));
         item.alt_prefix    = 1'($urandom_range(1, 0));
         item.upper_case    = 1'($urandom_range(1, 0));
         send_item(item, 1'b0, "");
      end
      req_push <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** hex_number_formatter: PASSED **");
      end else begin
         $display("** hex_number_formatter: FAILED **");
      end
      $finish;
   end

endmodule
